// ----- src/tli_pkg.sv -----
// Shared types and constants of the table linear interpolator.
// Used by tli_store, tli_arith and table_linear_interpolator; no dependencies.
package tli_pkg;

	localparam int DATA_W  = 32;
	localparam int MAG_W   = 33;
	localparam int PROD_W  = 66;
	localparam int QUOT_W  = 41;
	localparam int STEP_W  = 7;
	localparam int MUL_STEPS = 33;
	localparam int DIV_STEPS = 65;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] REGION_INTERIOR = 2'd0;
	localparam logic [1:0] REGION_LOW      = 2'd1;
	localparam logic [1:0] REGION_HIGH     = 2'd2;

	localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {(QUOT_W-1){1'b0}}};

	typedef struct packed {
		logic               cmd;
		logic [7:0]         point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_x;
	} tli_req_t;

	typedef struct packed {
		logic signed [31:0] interp_y;
		logic [1:0]         region;
	} tli_rsp_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} tli_point_t;

	// Launch of one multiply-then-divide run on the shared adder.
	typedef struct packed {
		logic             go;
		logic [MAG_W-1:0] ady;
		logic [MAG_W-1:0] adx;
		logic [MAG_W-1:0] agap;
	} tli_arith_req_t;

endpackage

// ----- src/tli_store.sv -----
// Point table: one write port and one registered read port.
// Depends on tli_pkg for the point type.
module tli_store import tli_pkg::*; #(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  tli_point_t    wr_data,
	input  logic [AW-1:0] rd_addr,
	output tli_point_t    rd_data
);

	tli_point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- src/tli_arith.sv -----
// Shared add/subtract unit: shift-add multiply, then restoring division.
// Depends on tli_pkg for widths and the launch struct.
module tli_arith import tli_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  tli_arith_req_t      op,
	output logic                done,
	output logic [QUOT_W-1:0]   quot
);

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} arith_state_t;

	arith_state_t       state_q;
	logic [PROD_W-1:0]  prod_q;
	logic [MAG_W-1:0]   rem_q;
	logic [MAG_W-1:0]   gap_q;
	logic [MAG_W-1:0]   mcand_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               done_q;

	logic [MAG_W+1:0]   a_op;
	logic [MAG_W+1:0]   b_op;
	logic [MAG_W+1:0]   sum;
	logic [MAG_W:0]     upper;
	logic               qbit;
	logic               big;

	// One adder serves both phases; the divide subtracts the gap from the
	// shifted remainder.
	always_comb begin
		if (state_q == A_MUL) begin
			a_op = {2'b00, prod_q[PROD_W-1:MAG_W]};
			b_op = {2'b00, mcand_q};
			sum  = a_op + b_op;
		end else begin
			a_op = {1'b0, rem_q, prod_q[PROD_W-2]};
			b_op = {2'b00, gap_q};
			sum  = a_op - b_op;
		end
		upper = prod_q[0] ? sum[MAG_W:0] : {1'b0, prod_q[PROD_W-1:MAG_W]};
		qbit  = ~sum[MAG_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			prod_q  <= '0;
			rem_q   <= '0;
			gap_q   <= '0;
			mcand_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (op.go) begin
						prod_q  <= {{(PROD_W-MAG_W){1'b0}}, op.adx};
						mcand_q <= op.ady;
						gap_q   <= op.agap;
						cnt_q   <= '0;
						state_q <= A_MUL;
					end
				end
				A_MUL: begin
					prod_q <= {upper, prod_q[MAG_W-1:1]};
					if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= A_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				A_DIV: begin
					prod_q <= {prod_q[PROD_W-2:0], qbit};
					rem_q  <= qbit ? sum[MAG_W-1:0] : a_op[MAG_W-1:0];
					if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= A_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	// The full quotient occupies the low 65 bits; clamp it at 2^40.
	assign big  = (|prod_q[PROD_W-2:QUOT_W]) ||
	              (prod_q[QUOT_W-1] && (|prod_q[QUOT_W-2:0]));
	assign quot = big ? QUOT_CAP : prod_q[QUOT_W-1:0];
	assign done = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("arith done held longer than one cycle");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		op.go |-> state_q == A_IDLE) else $error("arith launched while running");
	a_rem_below_gap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_DIV |-> rem_q < gap_q) else $error("division remainder not below divisor");

endmodule

// ----- src/table_linear_interpolator.sv -----
// Top level of the table linear interpolator: sequencer, config and result register.
// Depends on tli_pkg, tli_store and tli_arith.
//
//  channel   | signals                    | handshake
//  ----------+----------------------------+---------------------------------------
//  request   | start, busy, req           | taken when start is high, busy low
//  result    | done, rsp                  | one-cycle strobe, cannot be stalled
//  config    | cfg_wr_en, cfg_wr_data     | written on any edge with cfg_wr_en high
//
// A write request is stored without leaving idle, so busy stays low. A clamped query
// compares against the first point and, if it lies above it, the last point; an interior
// query then runs a binary search of table probes and, for a nonzero gap, a run on the
// shared adder (33 multiply steps, 65 divide steps). busy is high from the cycle after
// the request is taken; the result strobe comes in the first cycle with busy low again.
// Reset clears the sequencer and sets points_used to 2; the table is not cleared and
// must be written before it is read.
module table_linear_interpolator import tli_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data,
	input  logic       start,
	input  tli_req_t   req,
	output logic       busy,
	output logic       done,
	output tli_rsp_t   rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
	localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOW, ST_HIGH, ST_SEARCH, ST_PROBE, ST_LEFT, ST_RIGHT, ST_ARITH
	} seq_state_t;

	seq_state_t         state_q;
	logic [8:0]         points_used_q;
	logic signed [31:0] q_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic [AW-1:0]      mid_q;
	logic signed [31:0] xl_q;
	logic signed [31:0] yl_q;
	logic               neg_q;
	logic               done_q;
	tli_rsp_t           rsp_q;

	logic [AW-1:0]      n_last;
	logic [AW-1:0]      mid;
	logic [AW-1:0]      rd_addr;
	tli_point_t         rd_data;
	logic               wr_en;
	tli_point_t         wr_data;
	logic signed [32:0] gap_w;
	logic signed [32:0] dx_w;
	logic signed [32:0] dy_w;
	tli_arith_req_t     arith_op;
	logic               arith_done;
	logic [QUOT_W-1:0]  quot;
	logic signed [42:0] sum_w;
	logic signed [31:0] interp_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_used_q <= 9'd2;
		end else if (cfg_wr_en) begin
			points_used_q <= cfg_wr_data;
		end
	end

	// Index of the last point in use, with the count held to 2..TABLE_DEPTH.
	always_comb begin
		if (points_used_q < 9'd2) begin
			n_last = AW'(1);
		end else if (32'(points_used_q) > TABLE_DEPTH) begin
			n_last = LAST_IDX;
		end else begin
			n_last = AW'(points_used_q - 9'd1);
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign wr_en   = start && !busy && (req.cmd == CMD_WRITE) &&
	                 (32'(req.point_index) < TABLE_DEPTH);
	assign wr_data = '{x: req.point_x, y: req.point_y};
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		case (state_q)
			ST_IDLE:   rd_addr = '0;
			ST_LOW:    rd_addr = n_last;
			ST_SEARCH: rd_addr = (lo_q < hi_q) ? mid : lo_q - 1'b1;
			ST_LEFT:   rd_addr = lo_q;
			default:   rd_addr = '0;
		endcase
	end

	tli_store #(.DEPTH(TABLE_DEPTH)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(req.point_index)),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign gap_w = {rd_data.x[31], rd_data.x} - {xl_q[31], xl_q};
	assign dx_w  = {q_q[31], q_q} - {xl_q[31], xl_q};
	assign dy_w  = {rd_data.y[31], rd_data.y} - {yl_q[31], yl_q};

	always_comb begin
		arith_op.go   = (state_q == ST_RIGHT) && (gap_w != '0);
		arith_op.ady  = dy_w[32] ? (~dy_w + 33'd1) : dy_w;
		arith_op.adx  = dx_w[32] ? (~dx_w + 33'd1) : dx_w;
		arith_op.agap = gap_w[32] ? (~gap_w + 33'd1) : gap_w;
	end

	tli_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (arith_op),
		.done   (arith_done),
		.quot   (quot)
	);

	// The quotient is at most 2^40, so a 43-bit sum cannot overflow.
	always_comb begin
		if (neg_q) begin
			sum_w = {{11{yl_q[31]}}, yl_q} - $signed({2'b00, quot});
		end else begin
			sum_w = {{11{yl_q[31]}}, yl_q} + $signed({2'b00, quot});
		end
		if (sum_w > SAT_MAX) begin
			interp_sat = 32'sh7fffffff;
		end else if (sum_w < SAT_MIN) begin
			interp_sat = 32'sh80000000;
		end else begin
			interp_sat = sum_w[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			q_q     <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			xl_q    <= '0;
			yl_q    <= '0;
			neg_q   <= 1'b0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && (req.cmd == CMD_QUERY)) begin
						q_q     <= req.query_x;
						state_q <= ST_LOW;
					end
				end
				ST_LOW: begin
					if (q_q <= rd_data.x) begin
						rsp_q   <= '{interp_y: rd_data.y, region: REGION_LOW};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_HIGH;
					end
				end
				ST_HIGH: begin
					if (q_q >= rd_data.x) begin
						rsp_q   <= '{interp_y: rd_data.y, region: REGION_HIGH};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						lo_q    <= AW'(1);
						hi_q    <= n_last;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_PROBE;
					end else begin
						state_q <= ST_LEFT;
					end
				end
				ST_PROBE: begin
					if (rd_data.x < q_q) begin
						lo_q <= mid_q + 1'b1;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= ST_SEARCH;
				end
				ST_LEFT: begin
					xl_q    <= rd_data.x;
					yl_q    <= rd_data.y;
					state_q <= ST_RIGHT;
				end
				ST_RIGHT: begin
					if (gap_w == '0) begin
						rsp_q   <= '{interp_y: yl_q, region: REGION_INTERIOR};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						neg_q   <= gap_w[32] ^ dx_w[32] ^ dy_w[32];
						state_q <= ST_ARITH;
					end
				end
				ST_ARITH: begin
					if (arith_done) begin
						rsp_q   <= '{interp_y: interp_sat, region: REGION_INTERIOR};
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy)) else $error("result strobe without a query in flight");
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH || state_q == ST_PROBE) |->
		(lo_q != '0 && lo_q <= hi_q && hi_q <= n_last))
		else $error("binary search bounds out of order");
	a_arith_owner: assert property (@(posedge clk) disable iff (!arst_n)
		arith_done |-> state_q == ST_ARITH) else $error("arith finished outside its wait state");
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_QUERY) |=> state_q == ST_LOW)
		else $error("accepted query did not start the lookup");

endmodule
